// File: sv/escape_time_fractal_iterator_core_assert.svh
// Assertion macros for the escape-time fractal iterator.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every sampled edge.
`define ETFI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ETFI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ETFI_ASSERT(label, prop, msg)
`define ETFI_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: sv/etfi_pkg.sv
package etfi_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_HOLD
    } etfi_state_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_LIMIT     = 2'd1,
        REG_CONST_RE  = 2'd2,
        REG_CONST_IM  = 2'd3
    } etfi_reg_idx_t;

    localparam int CFG_IDX_W = 2;

    // Fractal modes
    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA      = 1'b1;

    // Register reset values
    localparam int LIMIT_RESET    = 50;
    localparam int CONST_RE_RESET = -107374182;
    localparam int CONST_IM_RESET = 161061274;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take a new point
        logic step;   // commit z = z*z + c, count up
        logic emit;   // copy the count into the output register
    } etfi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;   // escaped or limit reached for the current z
    } etfi_status_t;

endpackage

// File: sv/etfi_ctrl.sv
module etfi_ctrl
    import etfi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  etfi_status_t stat,
    output etfi_cmd_t    cmd
);

    etfi_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!stat.done)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
                else if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                // hold the finished count until the output register drains
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

endmodule

// File: sv/etfi_datapath.sv
module etfi_datapath
    import etfi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int ITER_BITS   = 10
)
(
    input  logic                          clk,
    input  etfi_cmd_t                     cmd,
    output etfi_status_t                  stat,
    input  logic                          mode,
    input  logic        [ITER_BITS-1:0]   limit,
    input  logic signed [COORD_WIDTH-1:0] const_re,
    input  logic signed [COORD_WIDTH-1:0] const_im,
    input  logic signed [COORD_WIDTH-1:0] point_re,
    input  logic signed [COORD_WIDTH-1:0] point_im,
    output logic        [ITER_BITS-1:0]   iter_count
);

    // z range: |z| < 8 + |c| after one step, plus sign
    localparam int ZW = ((COORD_WIDTH > FRAC_BITS + 4) ? COORD_WIDTH : FRAC_BITS + 4) + 2;
    // operand width once |re|, |im| < 2
    localparam int OW = FRAC_BITS + 2;
    localparam int PW = 2 * OW;
    localparam int DW = PW + 1;
    localparam int SW = DW - FRAC_BITS;

    localparam logic signed [ZW-1:0] TWO  = ZW'(2) << FRAC_BITS;
    localparam logic        [PW-1:0] FOUR = PW'(1) << (2 * FRAC_BITS + 2);

    logic signed [ZW-1:0]        z_re_reg, z_im_reg, c_re_reg, c_im_reg;
    logic        [ITER_BITS-1:0] count_reg, out_count_reg;
    logic signed [PW-1:0]        sq_re_reg, sq_im_reg, cross_reg;
    logic                        range_esc_reg;

    logic                 range_esc;
    logic signed [OW-1:0] op_re, op_im;
    logic        [PW-1:0] mag_sum;
    logic                 escape;
    logic signed [DW-1:0] diff, cross2;
    logic signed [SW-1:0] re_sc, im_sc;
    logic signed [ZW-1:0] new_re, new_im;

    // stage 1: coarse radius test and the three products
    assign range_esc = (z_re_reg >= TWO) || (z_re_reg <= -TWO) ||
                       (z_im_reg >= TWO) || (z_im_reg <= -TWO);
    assign op_re = z_re_reg[OW-1:0];
    assign op_im = z_im_reg[OW-1:0];

    // stage 2: exact radius test and the next z
    assign mag_sum = PW'(sq_re_reg) + PW'(sq_im_reg);
    assign escape  = range_esc_reg || (mag_sum >= FOUR);
    assign diff    = DW'(sq_re_reg) - DW'(sq_im_reg);
    assign cross2  = {cross_reg, 1'b0};
    assign re_sc   = diff[DW-1:FRAC_BITS];
    assign im_sc   = cross2[DW-1:FRAC_BITS];
    assign new_re  = ZW'(re_sc) + c_re_reg;
    assign new_im  = ZW'(im_sc) + c_im_reg;

    assign stat.done  = escape || !(count_reg < limit);
    assign iter_count = out_count_reg;

    always_ff @(posedge clk)
    begin
        range_esc_reg <= range_esc;
        sq_re_reg     <= PW'(op_re) * PW'(op_re);
        sq_im_reg     <= PW'(op_im) * PW'(op_im);
        cross_reg     <= PW'(op_re) * PW'(op_im);

        if (cmd.load)
        begin
            count_reg <= '0;
            if (mode == MODE_JULIA)
            begin
                z_re_reg <= ZW'(point_re);
                z_im_reg <= ZW'(point_im);
                c_re_reg <= ZW'(const_re);
                c_im_reg <= ZW'(const_im);
            end
            else
            begin
                z_re_reg <= '0;
                z_im_reg <= '0;
                c_re_reg <= ZW'(point_re);
                c_im_reg <= ZW'(point_im);
            end
        end
        else if (cmd.step)
        begin
            z_re_reg  <= new_re;
            z_im_reg  <= new_im;
            count_reg <= count_reg + ITER_BITS'(1);
        end

        if (cmd.emit)
        begin
            out_count_reg <= count_reg;
        end
    end

endmodule

// File: sv/escape_time_fractal_iterator_core.sv
// Escape-time iterator for Mandelbrot and Julia sets. Each item on the slave
// stream is one point (re, im) in signed fixed point (FRAC_BITS fraction bits);
// the master stream returns one iteration count per point, in order. Mode 0
// (Mandelbrot) starts z at zero with c = point; mode 1 (Julia) starts z at the
// point with c = the configured constant. The count stops when |z|^2 >= 4 or
// when it reaches limit_reg; a zero limit or a start outside the radius
// gives 0. One item is worked on at a time: each iteration runs through a
// product stage with three multipliers of FRAC_BITS+2 bits, then an update
// stage doing the exact radius test and the new z. A finished count is held
// in the core while the previous count still waits to be taken. The result
// sits in an output register, so the next point is taken while it waits.
// Write the configuration registers only while the core is idle.
`include "escape_time_fractal_iterator_core_assert.svh"

module escape_time_fractal_iterator_core
    import etfi_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int ITER_BITS   = 10,
    localparam int CFG_W = (COORD_WIDTH > ITER_BITS) ? COORD_WIDTH : ITER_BITS,
    localparam int IN_W  = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((ITER_BITS + 7) / 8) * 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data,
    // points in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [IN_W-1:0]                    s_tdata,  // point_re, point_im
    // counts out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [OUT_W-1:0]                   m_tdata   // iter_count
);

    localparam logic        [ITER_BITS-1:0]   LIMIT_RST = ITER_BITS'(LIMIT_RESET);
    localparam logic signed [COORD_WIDTH-1:0] JRE_RST   = COORD_WIDTH'(CONST_RE_RESET);
    localparam logic signed [COORD_WIDTH-1:0] JIM_RST   = COORD_WIDTH'(CONST_IM_RESET);

    logic                          mode_reg;
    logic        [ITER_BITS-1:0]   limit_reg;
    logic signed [COORD_WIDTH-1:0] const_re_reg, const_im_reg;

    logic signed [COORD_WIDTH-1:0] point_re, point_im;
    logic        [ITER_BITS-1:0]   iter_count;

    etfi_cmd_t    cmd;
    etfi_status_t stat;

    // configuration registers; write them only while the core is idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_MANDELBROT;
            limit_reg    <= LIMIT_RST;
            const_re_reg <= JRE_RST;
            const_im_reg <= JIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (etfi_reg_idx_t'(cfg_index))
                REG_MODE:     mode_reg     <= cfg_data[0];
                REG_LIMIT:    limit_reg    <= cfg_data[ITER_BITS-1:0];
                REG_CONST_RE: const_re_reg <= cfg_data[COORD_WIDTH-1:0];
                REG_CONST_IM: const_im_reg <= cfg_data[COORD_WIDTH-1:0];
            endcase
        end
    end

    // unpack the point: real part in the low half
    assign point_re = s_tdata[COORD_WIDTH-1:0];
    assign point_im = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    assign m_tdata = OUT_W'(iter_count);

    etfi_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    etfi_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ITER_BITS   (ITER_BITS)
    ) u_datapath
    (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode_reg),
        .limit      (limit_reg),
        .const_re   (const_re_reg),
        .const_im   (const_im_reg),
        .point_re   (point_re),
        .point_im   (point_im),
        .iter_count (iter_count)
    );

    // a freshly taken point leaves the core busy, with s_tready dropped
    `ETFI_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    // never overwrite a count that has not been taken
    `ETFI_ASSERT(a_emit_slot_free, !cmd.emit || !m_tvalid || m_tready, "output overwritten")
    // a delivered count never exceeds the limit
    `ETFI_ASSERT(a_count_in_limit, !m_tvalid || (iter_count <= limit_reg), "count above limit")

endmodule
